[rtl/pixel_brightness_contrast_saturation_defines.svh]
// Assertion macros shared by the pixel adjustment RTL.
// Included by files that carry concurrent assertions; depends on nothing.
`ifndef PIXEL_BRIGHTNESS_CONTRAST_SATURATION_DEFINES_SVH
`define PIXEL_BRIGHTNESS_CONTRAST_SATURATION_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PBCS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define PBCS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/pbcs_pkg.sv]
// Package of the pixel brightness/contrast/saturation block: widths, codes and types.
// Used by the interfaces, the divider, the factor unit and the top level.
package pbcs_pkg;

   localparam int PIX_W     = 8;
   localparam int AMT_W     = 8;
   localparam int CSR_IDX_W = 1;

   // Pipelined divider geometry for saturation and hue.
   localparam int DIV_Q_W    = 17;
   localparam int DIV_N_W    = 28;
   localparam int DIV_D_W    = 12;
   localparam int DIV_STAGES = DIV_Q_W;

   localparam int FACTOR_W = 24;
   localparam int STEP_W   = 18;

   localparam logic [DIV_Q_W-1:0] ONE_Q16 = 17'd65536;

   // Adjustment modes; the fourth code passes the pixel through.
   localparam logic [1:0] MODE_BRIGHT   = 2'd0;
   localparam logic [1:0] MODE_CONTRAST = 2'd1;
   localparam logic [1:0] MODE_SAT      = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_AMOUNT = 1'b1;

   typedef logic [2:0][PIX_W-1:0] pix_type;

   typedef enum logic [1:0] {
      FAC_LOAD,
      FAC_RUN,
      FAC_IDLE
   } fac_state_type;

   // Coefficients handed from the factor unit to the pixel pipeline.
   typedef struct packed {
      logic                     busy;
      logic [FACTOR_W-1:0]      factor;
      logic signed [STEP_W-1:0] step;
   } coef_type;

   // Data that rides alongside the divider.
   typedef struct packed {
      logic             valid;
      logic             dz;
      logic [PIX_W-1:0] mx;
      pix_type          other;
   } side_type;

endpackage

[rtl/pbcs_if.sv]
// Channel interfaces of the pixel adjustment block: input pixel, output pixel, register write.
// Depends on pbcs_pkg for the field widths.
interface pbcs_pix_in_if;
   logic                        valid;
   logic                        ready;
   logic [pbcs_pkg::PIX_W-1:0]  red_in;
   logic [pbcs_pkg::PIX_W-1:0]  green_in;
   logic [pbcs_pkg::PIX_W-1:0]  blue_in;
   modport source (output valid, red_in, green_in, blue_in, input ready);
   modport sink (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface pbcs_pix_out_if;
   logic                        valid;
   logic                        ready;
   logic [pbcs_pkg::PIX_W-1:0]  red_out;
   logic [pbcs_pkg::PIX_W-1:0]  green_out;
   logic [pbcs_pkg::PIX_W-1:0]  blue_out;
   modport source (output valid, red_out, green_out, blue_out, input ready);
   modport sink (input valid, red_out, green_out, blue_out, output ready);
endinterface

interface pbcs_csr_if;
   logic                            valid;
   logic                            ready;
   logic [pbcs_pkg::CSR_IDX_W-1:0]  index;
   logic [pbcs_pkg::AMT_W-1:0]      data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[rtl/pbcs_div.sv]
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on pbcs_pkg for its widths; the quotient must fit DIV_Q_W bits.
module pbcs_div (
   input  logic                            clock,
   input  logic                            en,
   input  logic [pbcs_pkg::DIV_N_W-1:0]    num_in,
   input  logic [pbcs_pkg::DIV_D_W-1:0]    den_in,
   output logic [pbcs_pkg::DIV_Q_W-1:0]    quot_out
);
   import pbcs_pkg::*;

   typedef logic [DIV_N_W:0] wide_type;

   logic [DIV_N_W-1:0] rem_ff [DIV_STAGES];
   logic [DIV_D_W-1:0] den_ff [DIV_STAGES];
   logic [DIV_Q_W-1:0] quo_ff [DIV_STAGES];

   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
      localparam int B = DIV_Q_W - 1 - j;
      logic [DIV_N_W-1:0] rem_src;
      logic [DIV_D_W-1:0] den_src;
      logic [DIV_Q_W-1:0] quo_src;
      wide_type           diff;
      logic               ge;
      logic [DIV_N_W-1:0] rem_in;
      logic [DIV_Q_W-1:0] quo_in;

      if (j == 0) begin : g_first
         assign rem_src = num_in;
         assign den_src = den_in;
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[j-1];
         assign den_src = den_ff[j-1];
         assign quo_src = quo_ff[j-1];
      end

      // Trial subtraction of the divisor shifted to this bit.
      always_comb begin
         diff   = wide_type'(rem_src) - (wide_type'(den_src) << B);
         ge     = ~diff[DIV_N_W];
         rem_in = ge ? diff[DIV_N_W-1:0] : rem_src;
         quo_in = quo_src;
         quo_in[B] = ge;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= rem_in;
            den_ff[j] <= den_src;
            quo_ff[j] <= quo_in;
         end
      end
   end

   assign quot_out = quo_ff[DIV_STAGES-1];

endmodule

[rtl/pbcs_factor.sv]
// Coefficient unit: contrast factor by a serial divider, and the saturation step.
// Depends on pbcs_pkg; recomputes after reset and after every register write.
module pbcs_factor (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              restart,
   input  logic signed [pbcs_pkg::AMT_W-1:0] amount,
   output pbcs_pkg::coef_type                coef_out
);
   import pbcs_pkg::*;

   localparam int FNUM_W = 34;
   localparam int FDEN_W = 22;
   localparam logic [5:0] LAST_BIT = 6'(FNUM_W - 1);

   fac_state_type state_ff, state_in;
   logic [5:0]              cnt_ff;
   logic [FNUM_W-1:0]       num_ff;
   logic [FNUM_W-1:0]       quo_ff;
   logic [FDEN_W-1:0]       rem_ff;
   logic [FDEN_W-1:0]       den2_ff;
   logic [FACTOR_W-1:0]     factor_ff;
   logic signed [STEP_W-1:0] step_ff;

   logic                    in_range;
   logic [7:0]              a_plus;
   logic signed [25:0]      den;
   logic [FNUM_W-1:0]       num2;
   logic [FDEN_W:0]         trial;
   logic [FDEN_W:0]         trial_diff;
   logic                    ge;
   logic [FNUM_W-1:0]       quo_next;
   logic [AMT_W-1:0]        a_abs;
   logic [12:0]             y;
   logic [24:0]             y_scaled;
   logic [16:0]             mag;

   // Numerator and denominator of the rounded factor quotient.
   always_comb begin
      in_range = (amount >= -8'sd100) && (amount <= 8'sd100);
      a_plus   = 8'(amount + 8'sd100);
      den      = 26'sd1000001 - 26'(amount) * 26'sd10000;
      num2     = FNUM_W'(a_plus) * FNUM_W'(81920000) + FNUM_W'(den);
   end

   // Step of amount/100 in signed Q1.16, rounded half away from zero.
   always_comb begin
      a_abs    = amount[AMT_W-1] ? AMT_W'(-amount) : AMT_W'(amount);
      y        = 13'(a_abs) * 13'd36 + 13'd50;
      y_scaled = 25'(y) * 25'd5243;
      mag      = 17'(a_abs) * 17'd655 + 17'(y_scaled[24:19]);
   end

   // One quotient bit per cycle while in FAC_RUN.
   always_comb begin
      trial      = {rem_ff, num_ff[FNUM_W-1]};
      trial_diff = trial - {1'b0, den2_ff};
      ge         = (trial >= {1'b0, den2_ff});
      quo_next   = {quo_ff[FNUM_W-2:0], ge};
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FAC_LOAD: state_in = in_range ? FAC_RUN : FAC_IDLE;
         FAC_RUN:  state_in = (cnt_ff == LAST_BIT) ? FAC_IDLE : FAC_RUN;
         FAC_IDLE: state_in = FAC_IDLE;
         default:  state_in = FAC_LOAD;
      endcase
      if (restart) begin
         state_in = FAC_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FAC_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // Divider datapath and coefficient registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         FAC_LOAD: begin
            num_ff  <= num2;
            den2_ff <= FDEN_W'(den) << 1;
            rem_ff  <= '0;
            quo_ff  <= '0;
            cnt_ff  <= '0;
            step_ff <= amount[AMT_W-1] ? -STEP_W'(mag) : STEP_W'(mag);
            if (!in_range) begin
               factor_ff <= '0;
            end
         end
         FAC_RUN: begin
            rem_ff <= ge ? trial_diff[FDEN_W-1:0] : trial[FDEN_W-1:0];
            num_ff <= {num_ff[FNUM_W-2:0], 1'b0};
            quo_ff <= quo_next;
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == LAST_BIT) begin
               factor_ff <= (|quo_next[FNUM_W-1:FACTOR_W]) ? {FACTOR_W{1'b1}}
                                                          : quo_next[FACTOR_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   // Outputs.
   always_comb begin
      coef_out.busy   = (state_ff != FAC_IDLE);
      coef_out.factor = factor_ff;
      coef_out.step   = step_ff;
   end

endmodule

[rtl/pixel_brightness_contrast_saturation.sv]
// Top level of the pixel brightness/contrast/saturation block.
// Depends on pbcs_pkg, the interfaces in pbcs_if, pbcs_div, pbcs_factor and the defines header.
//
//   Channel   Dir   Payload                          Beat when
//   req_pix   in    red_in, green_in, blue_in        valid && ready
//   rsp_pix   out   red_out, green_out, blue_out     valid && ready
//   csr_wr    in    index (mode, amount), data       valid && ready
//
// One pixel beat per cycle enters while no stall or coefficient update holds req_pix.ready low.
// The latency is set by the 17-stage hue and saturation dividers plus five other stages.
// After reset and after each register write, the coefficient unit recomputes with req_pix.ready
// low, running the serial contrast divider when the amount is in range; register writes are always taken.
// A stall on rsp_pix holds the whole pipeline in place.
`include "pixel_brightness_contrast_saturation_defines.svh"

module pixel_brightness_contrast_saturation (
   input  logic           clock,
   input  logic           reset,
   pbcs_pix_in_if.sink    req_pix,
   pbcs_pix_out_if.source rsp_pix,
   pbcs_csr_if.sink       csr_wr
);
   import pbcs_pkg::*;

   logic                    en;
   logic [1:0]              mode_ff;
   logic signed [AMT_W-1:0] amount_ff;
   coef_type                coef;
   logic                    csr_beat;

   // Stage 1: input register.
   logic    st1_v_ff;
   pix_type st1_pix_ff;

   // Stage 2: extrema, hue numerator, brightness and contrast products.
   logic [PIX_W-1:0]      mx, mn, delta;
   logic [11:0]           hnum;
   pix_type               bright;
   logic signed [33:0]    prod [3];
   logic                  st2_v_ff;
   pix_type               st2_pix_ff;
   logic [PIX_W-1:0]      st2_mx_ff, st2_delta_ff;
   logic [11:0]           st2_hnum_ff;
   pix_type               st2_bright_ff;
   logic signed [33:0]    st2_prod_ff [3];

   // Divider inputs and side line.
   logic [DIV_N_W-1:0] s_num, h_num;
   logic [DIV_D_W-1:0] s_den, h_den;
   logic [DIV_Q_W-1:0] s_quot, h_quot;
   side_type           side_in;
   side_type           side_ff [DIV_STAGES];
   logic signed [33:0] cn [3];

   // Stage X: new saturation and hue.
   logic [DIV_Q_W-1:0]  s_raw;
   logic signed [18:0]  s_sum;
   logic [DIV_Q_W-1:0]  sn;
   side_type            x_side_ff;
   logic [DIV_Q_W-1:0]  x_sn_ff;
   logic [15:0]         x_h_ff;

   // Stage Y: sextant, fraction products and p.
   logic [18:0]   h6;
   logic [16:0]   fc;
   logic [33:0]   sfc;
   logic [24:0]   pm;
   side_type      y_side_ff;
   logic          y_szero_ff;
   logic [2:0]    y_i_ff;
   logic [32:0]   y_sf_ff, y_sfc_ff;
   logic [PIX_W-1:0] y_p_ff;

   // Stage Z: output register.
   logic [32:0]   dq, dt;
   logic [40:0]   qm, tm;
   logic [PIX_W-1:0] q, t, v;
   pix_type       sat_pix, z_in;
   logic          z_v_ff;
   pix_type       z_pix_ff;

   // Global advance: move when the output register is free or being drained.
   assign en             = !z_v_ff || rsp_pix.ready;
   assign req_pix.ready  = en && !coef.busy;
   assign csr_wr.ready   = 1'b1;
   assign csr_beat       = csr_wr.valid && csr_wr.ready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_BRIGHT;
         amount_ff <= '0;
      end else if (csr_beat) begin
         case (csr_wr.index)
            CSR_MODE:   mode_ff   <= csr_wr.data[1:0];
            CSR_AMOUNT: amount_ff <= csr_wr.data;
            default: begin
            end
         endcase
      end
   end

   pbcs_factor u_factor (
      .clock    (clock),
      .reset    (reset),
      .restart  (csr_beat),
      .amount   (amount_ff),
      .coef_out (coef)
   );

   // Stage 1.
   always_ff @(posedge clock) begin
      if (reset) begin
         st1_v_ff <= 1'b0;
      end else if (en) begin
         st1_v_ff <= req_pix.valid && req_pix.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st1_pix_ff <= {req_pix.blue_in, req_pix.green_in, req_pix.red_in};
      end
   end

   // Extrema and hue numerator of the sextant holding the maximum.
   always_comb begin
      mx = st1_pix_ff[0];
      mn = st1_pix_ff[0];
      if (st1_pix_ff[1] > mx) mx = st1_pix_ff[1];
      if (st1_pix_ff[2] > mx) mx = st1_pix_ff[2];
      if (st1_pix_ff[1] < mn) mn = st1_pix_ff[1];
      if (st1_pix_ff[2] < mn) mn = st1_pix_ff[2];
      delta = mx - mn;
      if (st1_pix_ff[0] == mx) begin
         if (st1_pix_ff[1] >= st1_pix_ff[2]) begin
            hnum = 12'(st1_pix_ff[1]) - 12'(st1_pix_ff[2]);
         end else begin
            hnum = 12'(delta) * 12'd6 - (12'(st1_pix_ff[2]) - 12'(st1_pix_ff[1]));
         end
      end else if (st1_pix_ff[1] == mx) begin
         hnum = 12'(delta) * 12'd2 + 12'(st1_pix_ff[2]) - 12'(st1_pix_ff[0]);
      end else begin
         hnum = 12'(delta) * 12'd4 + 12'(st1_pix_ff[0]) - 12'(st1_pix_ff[1]);
      end
   end

   // Brightness sums and contrast products per channel.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic signed [9:0] sum;
         logic signed [9:0] c2;
         sum = $signed({2'b00, st1_pix_ff[k]}) + 10'(amount_ff);
         if (sum < 0) begin
            bright[k] = '0;
         end else if (sum > 10'sd255) begin
            bright[k] = 8'd255;
         end else begin
            bright[k] = sum[7:0];
         end
         c2      = $signed({1'b0, st1_pix_ff[k], 1'b0}) - 10'sd255;
         prod[k] = 34'(c2) * 34'($signed({1'b0, coef.factor}));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st2_v_ff <= 1'b0;
      end else if (en) begin
         st2_v_ff <= st1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st2_pix_ff    <= st1_pix_ff;
         st2_mx_ff     <= mx;
         st2_delta_ff  <= delta;
         st2_hnum_ff   <= hnum;
         st2_bright_ff <= bright;
         for (int k = 0; k < 3; k++) begin
            st2_prod_ff[k] <= prod[k];
         end
      end
   end

   // Rounded quotients: (2n + d) / (2d).
   always_comb begin
      s_num = {3'b000, st2_delta_ff, 17'b0} + DIV_N_W'(st2_mx_ff);
      s_den = {3'b000, st2_mx_ff, 1'b0};
      h_num = {st2_hnum_ff[10:0], 17'b0} + DIV_N_W'(12'(st2_delta_ff) * 12'd6);
      h_den = 12'(st2_delta_ff) * 12'd12;
   end

   pbcs_div u_div_s (
      .clock    (clock),
      .en       (en),
      .num_in   (s_num),
      .den_in   (s_den),
      .quot_out (s_quot)
   );

   pbcs_div u_div_h (
      .clock    (clock),
      .en       (en),
      .num_in   (h_num),
      .den_in   (h_den),
      .quot_out (h_quot)
   );

   // Result of the modes that skip the dividers; contrast is truncated and clamped.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         cn[k] = st2_prod_ff[k] + 34'sd1044480;
      end
      side_in.valid = st2_v_ff;
      side_in.dz    = (st2_delta_ff == '0);
      side_in.mx    = st2_mx_ff;
      case (mode_ff)
         MODE_BRIGHT: side_in.other = st2_bright_ff;
         MODE_CONTRAST: begin
            for (int k = 0; k < 3; k++) begin
               if (cn[k] < 0) begin
                  side_in.other[k] = '0;
               end else if (|cn[k][33:21]) begin
                  side_in.other[k] = 8'd255;
               end else begin
                  side_in.other[k] = cn[k][20:13];
               end
            end
         end
         default: side_in.other = st2_pix_ff;
      endcase
   end

   // Side line matching the divider latency; reset clears only the valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            side_ff[k].valid <= 1'b0;
         end
      end else if (en) begin
         side_ff[0] <= side_in;
         for (int k = 1; k < DIV_STAGES; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // Stage X: a grey pixel has zero hue and saturation; add the step and clamp.
   always_comb begin
      s_raw = side_ff[DIV_STAGES-1].dz ? '0 : s_quot;
      s_sum = $signed({2'b00, s_raw}) + 19'(coef.step);
      if (s_sum < 0) begin
         sn = '0;
      end else if (s_sum > $signed({2'b00, ONE_Q16})) begin
         sn = ONE_Q16;
      end else begin
         sn = s_sum[DIV_Q_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_side_ff.valid <= 1'b0;
      end else if (en) begin
         x_side_ff.valid <= side_ff[DIV_STAGES-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_side_ff.dz    <= side_ff[DIV_STAGES-1].dz;
         x_side_ff.mx    <= side_ff[DIV_STAGES-1].mx;
         x_side_ff.other <= side_ff[DIV_STAGES-1].other;
         x_sn_ff         <= sn;
         x_h_ff          <= side_ff[DIV_STAGES-1].dz ? '0 : h_quot[15:0];
      end
   end

   // Stage Y: sextant, fraction and the products of saturation with it.
   always_comb begin
      h6  = 19'(x_h_ff) * 19'd6;
      fc  = ONE_Q16 - {1'b0, h6[15:0]};
      sfc = 34'(x_sn_ff) * 34'(fc);
      pm  = 25'(x_side_ff.mx) * 25'(ONE_Q16 - x_sn_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         y_side_ff.valid <= 1'b0;
      end else if (en) begin
         y_side_ff.valid <= x_side_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         y_side_ff.dz    <= x_side_ff.dz;
         y_side_ff.mx    <= x_side_ff.mx;
         y_side_ff.other <= x_side_ff.other;
         y_szero_ff      <= (x_sn_ff == '0);
         y_i_ff          <= h6[18:16];
         y_sf_ff         <= 33'(x_sn_ff) * 33'(h6[15:0]);
         y_sfc_ff        <= sfc[32:0];
         y_p_ff          <= pm[23:16];
      end
   end

   // Stage Z: q and t, sextant selection and the mode choice.
   always_comb begin
      v  = y_side_ff.mx;
      dq = 33'h1_0000_0000 - y_sf_ff;
      dt = 33'h1_0000_0000 - y_sfc_ff;
      qm = 41'(v) * 41'(dq);
      tm = 41'(v) * 41'(dt);
      q  = qm[39:32];
      t  = tm[39:32];
      if (y_szero_ff) begin
         sat_pix = {v, v, v};
      end else begin
         case (y_i_ff)
            3'd0:    sat_pix = {y_p_ff, t, v};
            3'd1:    sat_pix = {y_p_ff, v, q};
            3'd2:    sat_pix = {t, v, y_p_ff};
            3'd3:    sat_pix = {v, q, y_p_ff};
            3'd4:    sat_pix = {v, y_p_ff, t};
            default: sat_pix = {q, y_p_ff, v};
         endcase
      end
      z_in = (mode_ff == MODE_SAT) ? sat_pix : y_side_ff.other;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         z_v_ff <= 1'b0;
      end else if (en) begin
         z_v_ff <= y_side_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         z_pix_ff <= z_in;
      end
   end

   assign rsp_pix.valid     = z_v_ff;
   assign rsp_pix.red_out   = z_pix_ff[0];
   assign rsp_pix.green_out = z_pix_ff[1];
   assign rsp_pix.blue_out  = z_pix_ff[2];

   // Checks on the pipeline and the coefficient unit.
   `PBCS_ASSERT_IMP(a_no_beat_while_busy, clock, reset, req_pix.ready, !coef.busy, "pixel taken while coefficients are stale")
   `PBCS_ASSERT_NEXT(a_write_restarts, clock, reset, csr_beat, coef.busy, "register write did not restart the coefficient unit")
   `PBCS_ASSERT_NEXT(a_stall_keeps_stage1, clock, reset, st1_v_ff && !en, st1_v_ff, "stalled pixel dropped from the first stage")
   `PBCS_ASSERT_NEXT(a_stall_keeps_side, clock, reset, !en, $stable(x_sn_ff) && $stable(y_i_ff), "pipeline moved during a stall")

endmodule
